[rtl/ersp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ersp_pkg;

	typedef logic [4:0] kind_t;

	typedef enum logic [3:0] {
		CLS_VALUE,
		CLS_RESP,
		CLS_FLAG,
		CLS_BIPAP,
		CLS_PAIR,
		CLS_LEAK,
		CLS_TRIPLE,
		CLS_FLOW,
		CLS_SUMMARY,
		CLS_BAD
	} rec_class_t;

	localparam int unsigned CODE_MAX = 18;

	localparam kind_t KIND_SNORE  = 5'd19;
	localparam kind_t KIND_SNORE2 = 5'd20;
	localparam kind_t KIND_IAP    = 5'd21;
	localparam kind_t KIND_BAD    = 5'd22;
	localparam kind_t KIND_TRUNC  = 5'd23;

	// Class of every 5-bit code; codes past the last record code are bad.
	localparam rec_class_t REC_CLASS [32] = '{
		CLS_VALUE, CLS_VALUE, CLS_VALUE, CLS_BIPAP,
		CLS_VALUE, CLS_RESP, CLS_RESP, CLS_RESP,
		CLS_BAD, CLS_BAD, CLS_RESP, CLS_PAIR,
		CLS_RESP, CLS_FLAG, CLS_TRIPLE, CLS_FLOW,
		CLS_TRIPLE, CLS_LEAK, CLS_SUMMARY, CLS_BAD,
		CLS_BAD, CLS_BAD, CLS_BAD, CLS_BAD,
		CLS_BAD, CLS_BAD, CLS_BAD, CLS_BAD,
		CLS_BAD, CLS_BAD, CLS_BAD, CLS_BAD
	};

	// Bytes that follow the code byte: time delta, if any, and data.
	localparam logic [2:0] REC_LEN [32] = '{
		3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd0, 3'd0, 3'd3, 3'd4, 3'd3, 3'd2, 3'd5, 3'd5,
		3'd5, 3'd4, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
	};

	localparam int unsigned HELD_DEPTH = 5;
	localparam int unsigned SLOTS      = 3;

endpackage

`default_nettype wire

[rtl/event_record_stream_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Event record stream parser.
// The input channel (in_valid, in_stall, data_byte, last_byte) takes one byte of an
// event log body per transaction; last_byte marks the final byte of a stream.
// The output channel (out_valid, out_stall, event_kind .. run_end) gives one event
// per transaction; run_end is set on the last event caused by one input byte.
// A byte is decoded in the cycle it is accepted and its events are held in a result
// register, so the first event appears in the cycle after the byte is taken.
// Bytes that cause no event or one event may follow back to back while the receiver
// does not stall. A byte that causes two or three events holds the input until its
// last event is taken; the result register hands out one event per unstalled cycle.
// The next byte is accepted in the same cycle as the last event of the previous one.
// When the receiver stalls, the shown event holds and the input stalls once the
// result register has no free room.
// base_time is written over the APB port and loaded at the first byte of a stream.
// Reset clears the parser to wait for the first code byte of a new stream and
// empties the result register.
module event_record_stream_parser
	import ersp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       event_kind,
	output logic [31:0]      event_time,
	output logic [15:0]      value_a,
	output logic [7:0]       value_b,
	output logic [15:0]      value_c,
	output logic [1:0]       value_count,
	output logic             run_end
);

	logic [31:0] base_time_q;
	kind_t       record_code_q;
	logic [2:0]  byte_pos_q;
	logic [7:0]  held_q [HELD_DEPTH];
	logic [31:0] running_time_q;
	logic        stream_start_q;
	logic        error_hold_q;

	logic        bnd_valid_q;
	logic [1:0]  bnd_num_q;
	logic [1:0]  bnd_idx_q;
	logic [31:0] bnd_time_q;
	kind_t       bnd_kind_q [SLOTS];
	logic [15:0] bnd_a_q [SLOTS];
	logic [7:0]  bnd_b_q;
	logic [15:0] bnd_c_q;
	logic [1:0]  bnd_cnt_q;

	logic        in_fire;
	logic        out_fire;
	logic        out_last;
	logic        cfg_write;

	logic [2:0]  wr_idx;
	logic [7:0]  hb [HELD_DEPTH];
	logic [7:0]  d0, d1, d2, d3;
	rec_class_t  cur_cls;
	rec_class_t  in_cls;
	logic [15:0] delta;
	logic [7:0]  offset;
	logic [17:0] adj;
	logic [31:0] t_fin;
	logic [31:0] t_ev;
	logic [31:0] cur_time;

	kind_t       nxt_code;
	logic [2:0]  nxt_pos;
	logic [31:0] nxt_running;
	logic        nxt_ss;
	logic        nxt_err;
	logic        held_we;

	logic [1:0]  res_num;
	logic [31:0] res_time;
	kind_t       res_kind [SLOTS];
	logic [15:0] res_a [SLOTS];
	logic [7:0]  res_b;
	logic [15:0] res_c;
	logic [1:0]  res_cnt;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign prdata    = (paddr[2] == 1'b0) ? base_time_q : 32'd0;

	assign out_valid = bnd_valid_q;
	assign out_fire  = bnd_valid_q & ~out_stall;
	assign out_last  = (bnd_idx_q == (bnd_num_q - 2'd1));
	assign in_stall  = bnd_valid_q & ~(out_fire & out_last);
	assign in_fire   = in_valid & ~in_stall;

	assign wr_idx = byte_pos_q - 3'd1;

	always_comb begin
		for (int i = 0; i < HELD_DEPTH; i++) begin
			hb[i] = ((byte_pos_q != 3'd0) && (wr_idx == 3'(i))) ? data_byte : held_q[i];
		end
	end

	assign cur_cls = REC_CLASS[record_code_q];
	assign in_cls  = REC_CLASS[data_byte[4:0]];

	assign d0 = (cur_cls == CLS_SUMMARY) ? hb[0] : hb[2];
	assign d1 = (cur_cls == CLS_SUMMARY) ? hb[1] : hb[3];
	assign d2 = (cur_cls == CLS_SUMMARY) ? hb[2] : hb[4];
	assign d3 = hb[3];

	// The summary record carries no time delta.
	assign delta  = (cur_cls == CLS_SUMMARY) ? 16'd0 : {hb[1], hb[0]};
	assign offset = (cur_cls == CLS_RESP) ? d0 : ((cur_cls == CLS_FLOW) ? d2 : 8'd0);
	assign adj    = {{2{delta[15]}}, delta} - {10'd0, offset};
	assign t_fin  = running_time_q + {{16{delta[15]}}, delta};
	assign t_ev   = running_time_q + {{14{adj[17]}}, adj};

	assign cur_time = stream_start_q ? base_time_q : running_time_q;

	always_comb begin
		nxt_code    = record_code_q;
		nxt_pos     = byte_pos_q;
		nxt_running = running_time_q;
		nxt_ss      = stream_start_q;
		nxt_err     = error_hold_q;
		held_we     = 1'b0;
		res_num     = 2'd0;
		res_time    = running_time_q;
		res_b       = 8'd0;
		res_c       = 16'd0;
		res_cnt     = 2'd1;
		for (int i = 0; i < SLOTS; i++) begin
			res_kind[i] = record_code_q;
			res_a[i]    = 16'd0;
		end

		if (error_hold_q) begin
			if (last_byte) begin
				nxt_err = 1'b0;
				nxt_ss  = 1'b1;
				nxt_pos = 3'd0;
			end
		end else if (byte_pos_q == 3'd0) begin
			nxt_running = cur_time;
			nxt_ss      = 1'b0;
			res_time    = cur_time;
			if ((data_byte > 8'(CODE_MAX)) || (in_cls == CLS_BAD)) begin
				res_num     = 2'd1;
				res_kind[0] = KIND_BAD;
				res_a[0]    = {8'd0, data_byte};
				if (last_byte) begin
					nxt_ss = 1'b1;
				end else begin
					nxt_err = 1'b1;
				end
			end else begin
				nxt_code = data_byte[4:0];
				nxt_pos  = 3'd1;
				if (last_byte) begin
					res_num     = 2'd1;
					res_kind[0] = KIND_TRUNC;
					res_a[0]    = {11'd0, data_byte[4:0]};
					nxt_ss      = 1'b1;
					nxt_pos     = 3'd0;
				end
			end
		end else begin
			held_we = 1'b1;
			if (byte_pos_q >= REC_LEN[record_code_q]) begin
				nxt_running = t_fin;
				nxt_pos     = 3'd0;
				res_time    = t_ev;
				res_num     = 2'd1;
				res_a[0]    = {8'd0, d0};
				unique case (cur_cls)
					CLS_FLAG: begin
						res_a[0] = 16'd0;
						res_cnt  = 2'd0;
					end
					CLS_BIPAP: begin
						res_num     = 2'd2;
						res_a[0]    = {8'd0, d1};
						res_kind[1] = KIND_IAP;
						res_a[1]    = {8'd0, d0};
					end
					CLS_PAIR: begin
						res_b   = d1;
						res_cnt = 2'd2;
					end
					CLS_LEAK: begin
						res_num     = (d1 != 8'd0) ? 2'd3 : 2'd2;
						res_kind[1] = KIND_SNORE;
						res_a[1]    = {8'd0, d1};
						res_kind[2] = KIND_SNORE2;
						res_a[2]    = {8'd0, d1};
					end
					CLS_TRIPLE: begin
						res_b   = d1;
						res_c   = {8'd0, d2};
						res_cnt = 2'd3;
					end
					CLS_FLOW: begin
						res_a[0] = {d1, d0};
						res_b    = d2;
						res_cnt  = 2'd2;
					end
					CLS_SUMMARY: begin
						res_b   = d1;
						res_c   = {d3, d2};
						res_cnt = 2'd3;
					end
					default: begin
					end
				endcase
			end else begin
				nxt_pos = byte_pos_q + 3'd1;
				if (last_byte) begin
					res_num     = 2'd1;
					res_kind[0] = KIND_TRUNC;
					res_a[0]    = {11'd0, record_code_q};
				end
			end
			if (last_byte) begin
				nxt_ss  = 1'b1;
				nxt_pos = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_time_q    <= 32'd0;
			record_code_q  <= '0;
			byte_pos_q     <= 3'd0;
			running_time_q <= 32'd0;
			stream_start_q <= 1'b1;
			error_hold_q   <= 1'b0;
		end else begin
			if (cfg_write && (paddr[2] == 1'b0)) begin
				base_time_q <= pwdata;
			end
			if (in_fire) begin
				record_code_q  <= nxt_code;
				byte_pos_q     <= nxt_pos;
				running_time_q <= nxt_running;
				stream_start_q <= nxt_ss;
				error_hold_q   <= nxt_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && held_we) begin
			held_q[wr_idx] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_valid_q <= 1'b0;
			bnd_idx_q   <= 2'd0;
			bnd_num_q   <= 2'd1;
		end else if (in_fire && (res_num != 2'd0)) begin
			bnd_valid_q <= 1'b1;
			bnd_idx_q   <= 2'd0;
			bnd_num_q   <= res_num;
		end else if (out_fire) begin
			if (out_last) begin
				bnd_valid_q <= 1'b0;
			end else begin
				bnd_idx_q <= bnd_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (res_num != 2'd0)) begin
			bnd_time_q <= res_time;
			bnd_kind_q <= res_kind;
			bnd_a_q    <= res_a;
			bnd_b_q    <= res_b;
			bnd_c_q    <= res_c;
			bnd_cnt_q  <= res_cnt;
		end
	end

	always_comb begin
		event_kind = bnd_kind_q[0];
		value_a    = bnd_a_q[0];
		if (bnd_idx_q == 2'd1) begin
			event_kind = bnd_kind_q[1];
			value_a    = bnd_a_q[1];
		end else if (bnd_idx_q == 2'd2) begin
			event_kind = bnd_kind_q[2];
			value_a    = bnd_a_q[2];
		end
	end

	assign event_time  = bnd_time_q;
	assign value_b     = bnd_b_q;
	assign value_c     = bnd_c_q;
	assign value_count = bnd_cnt_q;
	assign run_end     = out_last;

endmodule

`default_nettype wire
